[sv/circular_orbit_point_generator_unit_defines.svh]
// assertion macros for the orbit point generator
`ifndef CIRCULAR_ORBIT_POINT_GENERATOR_UNIT_DEFINES_SVH
`define CIRCULAR_ORBIT_POINT_GENERATOR_UNIT_DEFINES_SVH
// implication checked every cycle outside reset
`define COPG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication outside reset
`define COPG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[sv/copg_pkg.sv]
// ----------------------------------------------------------------------------
// copg_pkg
// shared types and constants of the circular orbit point generator
// ----------------------------------------------------------------------------
package copg_pkg;
   localparam int unsigned AngleFull    = 5760;
   localparam int unsigned AngleQuarter = 1440;
   localparam logic signed [33:0] CordicGain = 34'sh26DD3B6A;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQUARE, ST_SQRT, ST_THETA, ST_CORDIC, ST_SCALE, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      REG_CENTER_X = 3'd0, REG_CENTER_Y = 3'd1, REG_CENTER_Z = 3'd2,
      REG_PLANE = 3'd3, REG_START = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ORB_XY = 2'd0, ORB_XZ = 2'd1, ORB_YZ = 2'd2, ORB_NONE = 2'd3
   } plane_type;

   typedef enum logic [1:0] {
      UP_ZERO = 2'd0, UP_MINUS_Z = 2'd1, UP_MINUS_Y = 2'd2, UP_MINUS_X = 2'd3
   } up_type;

   function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
      logic [31:0] r;
      begin
         case (idx)
            5'd0: r = 32'h3243F6A8;  5'd1: r = 32'h1DAC6705;
            5'd2: r = 32'h0FADBAFC;  5'd3: r = 32'h07F56EA6;
            5'd4: r = 32'h03FEAB76;  5'd5: r = 32'h01FFD55B;
            5'd6: r = 32'h00FFFAAA;  5'd7: r = 32'h007FFF55;
            5'd8: r = 32'h003FFFEA;  5'd9: r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF; 5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF; 5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF; 5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF; 5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF; 5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF; 5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF; 5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F; 5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F; 5'd27: r = 32'h00000008;
            5'd28: r = 32'h00000004; 5'd29: r = 32'h00000002;
            5'd30: r = 32'h00000001; default: r = 32'h00000000;
         endcase
         return r;
      end
   endfunction

   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      begin
         if (v > 34'sh7FFFFFFF) return 32'h7FFFFFFF;
         else if (v < -34'sh80000000) return 32'h80000000;
         else return v[31:0];
      end
   endfunction
endpackage

[sv/copg_sqrt.sv]
// ----------------------------------------------------------------------------
// copg_sqrt
// bit-serial integer square root of a 64 bit value, one result bit a cycle
// ----------------------------------------------------------------------------
module copg_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [33:0] trial;
   logic [33:0] part;

   function automatic logic [1:0] radicand_sh(input logic [5:0] c);
      logic [5:0] pos;
      begin
         pos = 6'd62 - {c[4:0], 1'b0};
         return radicand[pos +: 2];
      end
   endfunction

   // restoring method: bring down two bits, try 4*root+1
   always_comb begin
      part    = {rem_ff[31:0], radicand_sh(cnt_ff)};
      trial   = {root_ff, 2'b01};
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = '0; root_in = '0; cnt_in = 6'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (part >= trial) begin
            rem_in  = part - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = part;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = busy_ff && (cnt_ff == 6'd31);
   assign root = root_in;
endmodule

[sv/circular_orbit_point_generator_unit.sv]
// ----------------------------------------------------------------------------
// circular_orbit_point_generator_unit
// places the camera on a circle about a programmable centre, cordic based
// ----------------------------------------------------------------------------
// channel  dir   handshake            contents
// req      in    req_valid/req_ready  camera position
// rsp      out   rsp_valid/rsp_ready  new position, up code, angle, radius
// csr      in    csr_we               centre, plane, start angle
//
// a request passes through the square, sqrt, theta, cordic, scale and out
// states from one acceptance to the next, its length set by the bit-serial
// square root and cordic add/shift unit; a saturated radius skips the root
// reset is synchronous; it clears the sequencer, the centre, the plane and the angle state
// req_ready is low from acceptance until the response has been taken, and a
// stalled rsp_ready holds the sequencer in the out state each stalled cycle
// ----------------------------------------------------------------------------
module circular_orbit_point_generator_unit #(
   parameter int unsigned ANGLE_STEP    = 16,
   parameter int unsigned CORDIC_STAGES = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_cam_x,
   input  logic [31:0] req_cam_y,
   input  logic [31:0] req_cam_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_new_x,
   output logic [31:0] rsp_new_y,
   output logic [31:0] rsp_new_z,
   output logic [1:0]  rsp_up_code,
   output logic [12:0] rsp_angle_used,
   output logic [31:0] rsp_orbit_radius,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int unsigned Stages = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam logic [12:0] StepMod = 13'(ANGLE_STEP % copg_pkg::AngleFull);

   // configuration
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [1:0]  plane_ff;
   logic [12:0] angle_ff, angle_in;

   copg_pkg::state_type state_ff, state_in;
   logic [5:0] step_ff, step_in;

   // working registers
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic [64:0] sum_ff;     // sum of squares plus overflow bit
   logic [31:0] radius_ff;
   logic signed [33:0] cx_acc_ff, cy_acc_ff;
   logic signed [32:0] z_ff;
   logic [1:0]  quad_ff;
   logic [10:0] rest_ff;
   logic [15:0] tnum_ff;
   logic signed [65:0] prod_ff;
   logic signed [33:0] oc_ff;
   logic [31:0] nx_ff, ny_ff, nz_ff;
   logic [1:0]  up_ff;
   logic [12:0] used_ff;

   // square root
   logic        sq_start, sq_done;
   logic [31:0] sq_root;

   copg_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .radicand(sum_ff[63:0]),
      .done    (sq_done),
      .root    (sq_root)
   );

   // squaring multiplier, one offset magnitude per cycle
   logic [32:0] mag;
   logic signed [32:0] dsel;
   logic [63:0] sq_prod;
   always_comb begin
      case (step_ff[1:0])
         2'd0:    dsel = dx_ff;
         2'd1:    dsel = dy_ff;
         default: dsel = dz_ff;
      endcase
      mag     = dsel[32] ? 33'(-dsel) : 33'(dsel);
      sq_prod = 64'(mag[31:0]) * 64'(mag[31:0]);
   end

   // 33 bit magnitude squared may exceed 64 bits only when mag[32] set
   logic [64:0] sq_wide;
   assign sq_wide = mag[32] ? {1'b1, 64'd0} : {1'b0, sq_prod};

   // theta = (r*pi_q30 + 1440) / 2880 with pi_q30 = 2880*1171270 + 1826:
   // r*1171270 plus (r*1826 + 1440) / 2880, the small quotient taken as
   // (x >> 6) / 45 by reciprocal multiplication (exact below 2^16)
   logic [21:0] tfrac;
   logic [32:0] tq;
   logic [32:0] theta;
   assign tfrac = 22'(rest_ff) * 22'd1826 + 22'd1440;
   assign tq    = 33'(tnum_ff) * 33'd93207;
   assign theta = 33'(rest_ff) * 33'd1171270 + 33'(tq[32:22]);

   // cordic micro-rotation
   logic signed [33:0] sx, sy;
   logic signed [32:0] at;
   assign sx = cx_acc_ff >>> step_ff[4:0];
   assign sy = cy_acc_ff >>> step_ff[4:0];
   assign at = 33'(copg_pkg::atan_lookup(step_ff[4:0]));

   // quadrant rotation of the final vector
   logic signed [33:0] cq, sq;
   always_comb begin
      case (quad_ff)
         2'd0:    begin cq = cx_acc_ff;  sq = cy_acc_ff;  end
         2'd1:    begin cq = -cy_acc_ff; sq = cx_acc_ff;  end
         2'd2:    begin cq = -cx_acc_ff; sq = -cy_acc_ff; end
         default: begin cq = cy_acc_ff;  sq = -cx_acc_ff; end
      endcase
   end

   logic signed [65:0] scale_prod;
   assign scale_prod = $signed({2'b00, radius_ff}) * (step_ff[0] ? sq : cq)
                       + 66'sd536870912;

   // new point: offsets added in the chosen plane, centre elsewhere
   logic signed [33:0] os_val;
   logic [31:0] nx_in, ny_in, nz_in;
   logic [1:0]  up_in;
   assign os_val = 34'(prod_ff >>> 30);
   always_comb begin
      nx_in = cx_ff;
      ny_in = cy_ff;
      nz_in = cz_ff;
      up_in = copg_pkg::UP_ZERO;
      unique case (plane_ff)
         copg_pkg::ORB_XY: begin
            nx_in = copg_pkg::sat32(34'(cx_ff) + oc_ff);
            ny_in = copg_pkg::sat32(34'(cy_ff) + os_val);
            up_in = copg_pkg::UP_MINUS_Z;
         end
         copg_pkg::ORB_XZ: begin
            nx_in = copg_pkg::sat32(34'(cx_ff) + oc_ff);
            nz_in = copg_pkg::sat32(34'(cz_ff) + os_val);
            up_in = copg_pkg::UP_MINUS_Y;
         end
         copg_pkg::ORB_YZ: begin
            ny_in = copg_pkg::sat32(34'(cy_ff) + oc_ff);
            nz_in = copg_pkg::sat32(34'(cz_ff) + os_val);
            up_in = copg_pkg::UP_MINUS_X;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         copg_pkg::ST_IDLE:
            if (req_valid) begin state_in = copg_pkg::ST_SQUARE; step_in = '0; end
         copg_pkg::ST_SQUARE:
            if (step_ff == 6'd2) state_in = copg_pkg::ST_SQRT;
            else step_in = step_ff + 6'd1;
         copg_pkg::ST_SQRT:
            if (sum_ff[64] || sq_done) state_in = copg_pkg::ST_THETA;
         copg_pkg::ST_THETA:
            begin state_in = copg_pkg::ST_CORDIC; step_in = '0; end
         copg_pkg::ST_CORDIC:
            if (step_ff == 6'(Stages - 1)) begin
               state_in = copg_pkg::ST_SCALE; step_in = '0;
            end else step_in = step_ff + 6'd1;
         copg_pkg::ST_SCALE:
            if (step_ff == 6'd2) state_in = copg_pkg::ST_OUT;
            else step_in = step_ff + 6'd1;
         copg_pkg::ST_OUT:
            if (rsp_ready) state_in = copg_pkg::ST_IDLE;
         default: state_in = copg_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = (state_ff == copg_pkg::ST_IDLE);
      rsp_valid = (state_ff == copg_pkg::ST_OUT);
      sq_start  = (state_ff == copg_pkg::ST_SQUARE) && (step_ff == 6'd2);
   end

   // angle: csr write reloads, finished request advances
   logic [13:0] start_red, adv;
   always_comb begin
      start_red = {1'b0, csr_wdata[12:0]};
      if (start_red >= 14'(copg_pkg::AngleFull))
         start_red = start_red - 14'(copg_pkg::AngleFull);
      adv = 14'(angle_ff) + 14'(StepMod);
      if (adv >= 14'(copg_pkg::AngleFull)) adv = adv - 14'(copg_pkg::AngleFull);
      angle_in = angle_ff;
      if (csr_we && csr_index == copg_pkg::REG_START) angle_in = start_red[12:0];
      else if (state_ff == copg_pkg::ST_OUT && rsp_ready) angle_in = adv[12:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= copg_pkg::ST_IDLE;
         step_ff  <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         cz_ff    <= '0;
         plane_ff <= '0;
         angle_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         angle_ff <= angle_in;
         if (csr_we) begin
            unique case (csr_index)
               copg_pkg::REG_CENTER_X: cx_ff <= csr_wdata;
               copg_pkg::REG_CENTER_Y: cy_ff <= csr_wdata;
               copg_pkg::REG_CENTER_Z: cz_ff <= csr_wdata;
               copg_pkg::REG_PLANE:    plane_ff <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         copg_pkg::ST_IDLE: begin
            dx_ff  <= $signed({req_cam_x[31], req_cam_x}) - $signed({cx_ff[31], cx_ff});
            dy_ff  <= $signed({req_cam_y[31], req_cam_y}) - $signed({cy_ff[31], cy_ff});
            dz_ff  <= $signed({req_cam_z[31], req_cam_z}) - $signed({cz_ff[31], cz_ff});
            sum_ff <= '0;
            used_ff <= angle_ff;
            quad_ff <= (angle_ff >= 13'd4320) ? 2'd3 : (angle_ff >= 13'd2880) ? 2'd2 :
                       (angle_ff >= 13'd1440) ? 2'd1 : 2'd0;
            rest_ff <= (angle_ff >= 13'd4320) ? 11'(angle_ff - 13'd4320) :
                       (angle_ff >= 13'd2880) ? 11'(angle_ff - 13'd2880) :
                       (angle_ff >= 13'd1440) ? 11'(angle_ff - 13'd1440) : angle_ff[10:0];
         end
         copg_pkg::ST_SQUARE: begin
            if (sum_ff[64] || sq_wide[64]) sum_ff <= {1'b1, 64'd0};
            else sum_ff <= sum_ff + sq_wide;
            tnum_ff <= tfrac[21:6];
         end
         copg_pkg::ST_SQRT: begin
            if (sum_ff[64]) radius_ff <= 32'hFFFFFFFF;
            else if (sq_done) radius_ff <= sq_root;
         end
         copg_pkg::ST_THETA: begin
            z_ff      <= theta;
            cx_acc_ff <= copg_pkg::CordicGain;
            cy_acc_ff <= '0;
         end
         copg_pkg::ST_CORDIC: begin
            if (!z_ff[32]) begin
               cx_acc_ff <= cx_acc_ff - sy;
               cy_acc_ff <= cy_acc_ff + sx;
               z_ff      <= z_ff - at;
            end else begin
               cx_acc_ff <= cx_acc_ff + sy;
               cy_acc_ff <= cy_acc_ff - sx;
               z_ff      <= z_ff + at;
            end
         end
         copg_pkg::ST_SCALE: begin
            prod_ff <= scale_prod;
            if (step_ff == 6'd1) oc_ff <= 34'(prod_ff >>> 30);
            if (step_ff == 6'd2) begin
               nx_ff <= nx_in;
               ny_ff <= ny_in;
               nz_ff <= nz_in;
               up_ff <= up_in;
            end
         end
         default: ;
      endcase
   end

   assign rsp_new_x        = nx_ff;
   assign rsp_new_y        = ny_ff;
   assign rsp_new_z        = nz_ff;
   assign rsp_up_code      = up_ff;
   assign rsp_angle_used   = used_ff;
   assign rsp_orbit_radius = radius_ff;
endmodule

[sv/copg_checker.sv]
// ----------------------------------------------------------------------------
// copg_checker
// port-level checks of the orbit point generator
// ----------------------------------------------------------------------------
`include "circular_orbit_point_generator_unit_defines.svh"
module copg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_up_code,
   input logic [12:0] rsp_angle_used
);
   `COPG_ASSERT_IMP(a_not_both, clock, reset, 1'b1, !(req_ready && rsp_valid), "ready while busy")
   `COPG_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready after request")
   `COPG_ASSERT_IMP(a_angle_range, clock, reset, rsp_valid, rsp_angle_used < 13'd5760, "angle range")
   `COPG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_up_code), "response dropped")
endmodule

bind circular_orbit_point_generator_unit copg_checker u_copg_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_up_code(rsp_up_code),
   .rsp_angle_used(rsp_angle_used)
);
